[rtl/hmrt_pkg.sv]
// Package for the HID mouse report translator: report and plan types, scancodes.
// Used by hmrt_plan, hid_mouse_report_translator_unit and the testbench; depends on nothing.

package hmrt_pkg;

    localparam logic [3:0] LEN_MIN  = 4'd3;
    localparam logic [3:0] LEN_LONG = 4'd4;
    localparam logic [3:0] LEN_MAX  = 4'd8;

    localparam logic [7:0] HDR_BASE     = 8'hF8;
    localparam logic [7:0] SC_MID_PRESS = 8'h37;
    localparam logic [7:0] SC_MID_REL   = 8'hB7;
    localparam logic [3:0] WHEEL_UP1    = 4'h1;
    localparam logic [3:0] WHEEL_UP2    = 4'h2;
    localparam logic [3:0] WHEEL_DN2    = 4'hE;
    localparam logic [3:0] WHEEL_DN1    = 4'hF;
    localparam logic [7:0] SC_WHEEL_1   = 8'h59;
    localparam logic [7:0] SC_WHEEL_2   = 8'h5D;
    localparam logic [7:0] SC_WHEEL_E   = 8'h5C;
    localparam logic [7:0] SC_WHEEL_F   = 8'h5A;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic              transfer_error;
        logic [3:0]        report_length;
        logic [7:0]        buttons;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic [7:0]        extra_byte;
    } t_report;

    typedef struct packed {
        logic              emit;
        logic              mid_en;
        logic [7:0]        mid_code;
        logic              wheel_en;
        logic [7:0]        wheel_code;
        logic [7:0]        header;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic [7:0]        keep_buttons;
        logic [7:0]        keep_extra;
    } t_plan;

endpackage

[rtl/hmrt_plan.sv]
// Decodes one registered mouse report into the scancode and packet items it causes.
// Depends on hmrt_pkg.

module hmrt_plan (
    input  hmrt_pkg::t_report i_report,
    input  logic [7:0]        i_prev_buttons,
    input  logic [7:0]        i_prev_extra,
    output hmrt_pkg::t_plan   o_plan
);

    logic       w_good;
    logic       w_long;
    logic [7:0] w_extra;
    logic       w_changed;

    always_comb begin
        w_good  = !i_report.transfer_error
                  && (i_report.report_length >= hmrt_pkg::LEN_MIN)
                  && (i_report.report_length <= hmrt_pkg::LEN_MAX);
        w_long  = (i_report.report_length >= hmrt_pkg::LEN_LONG);
        w_extra = w_long ? i_report.extra_byte : 8'd0;
        w_changed = (i_report.buttons != i_prev_buttons)
                    || (i_report.delta_x != 8'sd0) || (i_report.delta_y != 8'sd0)
                    || (w_long && (w_extra != i_prev_extra));

        o_plan.emit     = w_good && w_changed;
        o_plan.mid_en   = (i_report.buttons[2] != i_prev_buttons[2]);
        o_plan.mid_code = i_report.buttons[2] ? hmrt_pkg::SC_MID_PRESS
                                              : hmrt_pkg::SC_MID_REL;

        o_plan.wheel_en = 1'b1;
        unique case (w_extra[3:0])
            hmrt_pkg::WHEEL_UP1: o_plan.wheel_code = hmrt_pkg::SC_WHEEL_1;
            hmrt_pkg::WHEEL_UP2: o_plan.wheel_code = hmrt_pkg::SC_WHEEL_2;
            hmrt_pkg::WHEEL_DN2: o_plan.wheel_code = hmrt_pkg::SC_WHEEL_E;
            hmrt_pkg::WHEEL_DN1: o_plan.wheel_code = hmrt_pkg::SC_WHEEL_F;
            default: begin
                o_plan.wheel_en   = 1'b0;
                o_plan.wheel_code = 8'd0;
            end
        endcase

        o_plan.header = hmrt_pkg::HDR_BASE
                        | {6'd0, i_report.buttons[0], i_report.buttons[1]};
        o_plan.move_x       = i_report.delta_x;
        o_plan.move_y       = i_report.delta_y;
        o_plan.keep_buttons = i_report.buttons;
        o_plan.keep_extra   = w_extra;
    end

endmodule

[rtl/hid_mouse_report_translator_unit.sv]
// Top level of the HID mouse report translator: input register, decode, beat buffer.
// Depends on hmrt_pkg and hmrt_plan.
//
//   Channel   Direction  Beat
//   s_axis    in         one mouse report (tuser: transfer_error)
//   m_axis    out        one scancode or packet item (tuser: item_kind, tlast: last_of_run)
//
// A report is registered on acceptance and decoded from that register; once the beat
// buffer is free, its zero to three beats load the buffer, and the first one is offered.
// The buffer sends one beat per cycle while m_axis_tready is high.
// A new report is accepted while the buffer still drains its last beat.
// Synchronous reset clears the valid flags, the pending beats and the kept state.

module hid_mouse_report_translator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // report_length[3:0], buttons[11:4], delta_x[19:12], delta_y[27:20],
    // extra_byte[35:28], zero fill[39:36]
    input  logic [hmrt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // transfer_error[0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // first_byte[7:0], move_x[15:8], move_y[23:16]
    output logic [hmrt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // item_kind[0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic              r_in_valid;
    hmrt_pkg::t_report r_in;
    logic [7:0]        r_prev_buttons;
    logic [7:0]        r_prev_extra;
    logic [2:0]        r_pend;
    logic [2:0]        n_pend;
    logic [7:0]        r_mid_code;
    logic [7:0]        r_wheel_code;
    logic [7:0]        r_header;
    logic [7:0]        r_move_x;
    logic [7:0]        r_move_y;

    hmrt_pkg::t_plan   w_plan;
    logic              w_take;
    logic [2:0]        w_pend_rest;
    logic              w_out_free;
    logic              w_advance;
    logic              w_pkt;

    hmrt_plan u_plan (
        .i_report       (r_in),
        .i_prev_buttons (r_prev_buttons),
        .i_prev_extra   (r_prev_extra),
        .o_plan         (w_plan)
    );

    always_comb begin
        w_take        = m_axis_tvalid && m_axis_tready;
        w_pend_rest   = r_pend & (r_pend - 3'd1);
        w_out_free    = (r_pend == 3'd0) || (w_take && (w_pend_rest == 3'd0));
        w_advance     = r_in_valid && (!w_plan.emit || w_out_free);
        s_axis_tready = !r_in_valid || w_advance;

        if (w_advance && w_plan.emit) begin
            n_pend = {1'b1, w_plan.wheel_en, w_plan.mid_en};
        end else if (w_take) begin
            n_pend = w_pend_rest;
        end else begin
            n_pend = r_pend;
        end

        w_pkt         = !r_pend[0] && !r_pend[1];
        m_axis_tvalid = (r_pend != 3'd0);
        m_axis_tuser  = w_pkt;
        m_axis_tlast  = w_pkt;
        if (r_pend[0]) begin
            m_axis_tdata = {16'd0, r_mid_code};
        end else if (r_pend[1]) begin
            m_axis_tdata = {16'd0, r_wheel_code};
        end else begin
            m_axis_tdata = {r_move_y, r_move_x, r_header};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_pend         <= 3'd0;
            r_prev_buttons <= 8'd0;
            r_prev_extra   <= 8'd0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_pend <= n_pend;
            if (w_advance && w_plan.emit) begin
                r_prev_buttons <= w_plan.keep_buttons;
                r_prev_extra   <= w_plan.keep_extra;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.transfer_error <= s_axis_tuser;
            r_in.report_length  <= s_axis_tdata[3:0];
            r_in.buttons        <= s_axis_tdata[11:4];
            r_in.delta_x        <= s_axis_tdata[19:12];
            r_in.delta_y        <= s_axis_tdata[27:20];
            r_in.extra_byte     <= s_axis_tdata[35:28];
        end
        if (w_advance && w_plan.emit) begin
            r_mid_code   <= w_plan.mid_code;
            r_wheel_code <= w_plan.wheel_code;
            r_header     <= w_plan.header;
            r_move_x     <= w_plan.move_x;
            r_move_y     <= w_plan.move_y;
        end
    end

`ifndef SYNTH
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_pend == 3'd0) && !r_in_valid)
        else $error("Beat buffer or input register not cleared by reset.");

    a_last_is_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("The end of run does not fall on the mouse packet.");

    a_scancode_no_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:8] == 16'd0))
        else $error("Scancode beat carries motion bytes.");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && w_plan.emit && (r_pend != 3'd0))
        else $error("Input stalled without a pending report.");

    a_packet_always_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != 3'd0) |-> r_pend[2])
        else $error("Scancode beats pending without the closing packet.");
`endif

endmodule

[tb/hmrt_translation_check.sv]
// Checker for the HID mouse report translator: watches both stream channels,
// predicts the scancode and packet beats of every accepted report and compares them.
// Depends on hmrt_pkg for the report type and the scancode constants.
`timescale 1ns / 100ps

module hmrt_translation_check
    import hmrt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_m_tlast,
    output int                    o_fail_count,
    output int                    o_pending_count
);

    localparam logic KIND_SCANCODE = 1'b0;
    localparam logic KIND_PACKET   = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [7:0]        first_byte;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic              last;
    } t_out_beat;

    t_out_beat   expected_beats[$];
    logic [7:0]  kept_buttons;
    logic [7:0]  kept_extra;
    int          mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: mismatch in %s, expected %h, got %h", $time, field, want, got);
        mismatch_total++;
    endtask

    function automatic void push_beat(input logic kind, input logic [7:0] first_byte,
                                      input logic [7:0] mx, input logic [7:0] my,
                                      input logic last);
        t_out_beat b;
        b.kind       = kind;
        b.first_byte = first_byte;
        b.move_x     = mx;
        b.move_y     = my;
        b.last       = last;
        expected_beats.push_back(b);
    endfunction

    function automatic void translate_report(input t_report rpt);
        logic       long_rep;
        logic [7:0] extra;
        logic [7:0] header;
        logic [7:0] wheel_code;
        logic       changed;
        if (rpt.transfer_error || rpt.report_length < LEN_MIN
                || rpt.report_length > LEN_MAX) begin
            return;
        end
        long_rep = (rpt.report_length >= LEN_LONG);
        extra    = long_rep ? rpt.extra_byte : 8'h00;
        changed  = (rpt.buttons != kept_buttons) || (rpt.delta_x != 0)
                   || (rpt.delta_y != 0) || (long_rep && extra != kept_extra);
        if (!changed) begin
            return;
        end
        header = HDR_BASE | {6'b0, rpt.buttons[0], rpt.buttons[1]};
        if (rpt.buttons[2] != kept_buttons[2]) begin
            push_beat(KIND_SCANCODE, rpt.buttons[2] ? SC_MID_PRESS : SC_MID_REL,
                      8'h00, 8'h00, 1'b0);
        end
        case (extra[3:0])
            WHEEL_UP1: wheel_code = SC_WHEEL_1;
            WHEEL_UP2: wheel_code = SC_WHEEL_2;
            WHEEL_DN2: wheel_code = SC_WHEEL_E;
            WHEEL_DN1: wheel_code = SC_WHEEL_F;
            default:   wheel_code = 8'h00;
        endcase
        if (wheel_code != 8'h00) begin
            push_beat(KIND_SCANCODE, wheel_code, 8'h00, 8'h00, 1'b0);
        end
        push_beat(KIND_PACKET, header, rpt.delta_x, rpt.delta_y, 1'b1);
        kept_buttons = rpt.buttons;
        kept_extra   = extra;
    endfunction

    always @(posedge i_clk) begin : watch
        t_report   rpt;
        t_out_beat seen;
        t_out_beat want;
        if (!i_rst_n) begin
            expected_beats.delete();
            kept_buttons = 8'h00;
            kept_extra   = 8'h00;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.kind       = i_m_tuser;
                seen.first_byte = i_m_tdata[7:0];
                seen.move_x     = i_m_tdata[15:8];
                seen.move_y     = i_m_tdata[23:16];
                seen.last       = i_m_tlast;
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", 8'h00, seen.first_byte);
                end else begin
                    want = expected_beats.pop_front();
                    if (seen.kind != want.kind)
                        report_mismatch("item_kind", {7'd0, want.kind}, {7'd0, seen.kind});
                    if (seen.first_byte != want.first_byte)
                        report_mismatch("first_byte", want.first_byte, seen.first_byte);
                    if (seen.move_x != want.move_x)
                        report_mismatch("move_x", want.move_x, seen.move_x);
                    if (seen.move_y != want.move_y)
                        report_mismatch("move_y", want.move_y, seen.move_y);
                    if (seen.last != want.last)
                        report_mismatch("last_of_run", {7'd0, want.last}, {7'd0, seen.last});
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                rpt.transfer_error = i_s_tuser;
                rpt.report_length  = i_s_tdata[3:0];
                rpt.buttons        = i_s_tdata[11:4];
                rpt.delta_x        = i_s_tdata[19:12];
                rpt.delta_y        = i_s_tdata[27:20];
                rpt.extra_byte     = i_s_tdata[35:28];
                translate_report(rpt);
            end
        end
        o_pending_count <= expected_beats.size();
    end

endmodule

[tb/hid_mouse_report_translator_unit_tb.sv]
// Top of the translator testbench: clock, reset, report stimulus and output stalls.
// Instantiates hid_mouse_report_translator_unit and hmrt_translation_check.
`timescale 1ns / 100ps

module hid_mouse_report_translator_unit_tb;

    import hmrt_pkg::*;

    localparam int GOOD_REPORTS = 150;
    localparam int CALM_FROM    = 125;
    localparam int CYCLE_LIMIT  = 200000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int         fail_count;
    int         pending_count;
    int         cycle_count = 0;
    int         stall_left = 0;
    logic       calm = 1'b0;
    logic [7:0] sent_buttons = 8'h00;
    logic [7:0] sent_extra = 8'h00;

    hid_mouse_report_translator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    hmrt_translation_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // A gap, if any, is taken before the beat is offered.
    task automatic drive_report(input logic err, input logic [3:0] len,
                                input logic [7:0] btn, input logic [7:0] dx,
                                input logic [7:0] dy, input logic [7:0] ext);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= err;
        s_axis_tdata  <= {4'b0, ext, dy, dx, btn, len};
        do @(posedge i_clk); while (!s_axis_tready);
        if (!err && len >= LEN_MIN && len <= LEN_MAX
                && (btn != sent_buttons || dx != 0 || dy != 0
                    || (len >= LEN_LONG && ext != sent_extra))) begin
            sent_buttons = btn;
            sent_extra   = (len >= LEN_LONG) ? ext : 8'h00;
        end
    endtask

    task automatic random_report(output logic counted);
        int         pick;
        logic [3:0] len;
        logic [7:0] btn;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] ext;
        logic [3:0] wheel_nibbles[4];
        pick = $urandom_range(0, 99);
        wheel_nibbles = '{WHEEL_UP1, WHEEL_UP2, WHEEL_DN2, WHEEL_DN1};
        counted = 1'b0;
        if (pick < 8) begin
            if ($urandom_range(0, 1) == 0) begin
                drive_report(1'b1, 4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom));
            end else begin
                len = 4'($urandom_range(0, 9));
                len = (len < 4'd3) ? len : len + 4'd6;
                drive_report(1'b0, len, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end
        end else if (pick < 18) begin
            drive_report(1'b0, 4'($urandom_range(3, 8)), sent_buttons, 8'h00, 8'h00,
                         sent_extra);
        end else begin
            len = 4'($urandom_range(3, 8));
            btn = ($urandom_range(0, 1) == 0) ? (sent_buttons ^ 8'($urandom_range(0, 7)))
                                              : 8'($urandom);
            dx  = ($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom);
            dy  = ($urandom_range(0, 9) < 4) ? 8'h00 : 8'($urandom);
            ext = 8'($urandom);
            if ($urandom_range(0, 1) == 0)
                ext[3:0] = wheel_nibbles[2'($urandom_range(0, 3))];
            drive_report(1'b0, len, btn, dx, dy, ext);
            counted = 1'b1;
        end
    endtask

    initial begin : stimulus
        int   good_count;
        logic counted;
        good_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        drive_report(1'b1, 4'd3, 8'h01, 8'h05, 8'h00, 8'h00);
        drive_report(1'b0, 4'd0, 8'h01, 8'h05, 8'h05, 8'h01);
        drive_report(1'b0, 4'd2, 8'h02, 8'h00, 8'h07, 8'h02);
        drive_report(1'b0, 4'd9, 8'h04, 8'h01, 8'h00, 8'h0F);
        drive_report(1'b0, 4'd15, 8'hFF, 8'h80, 8'h7F, 8'hFF);
        drive_report(1'b0, 4'd3, 8'h00, 8'h00, 8'h00, 8'hAA);
        drive_report(1'b0, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00);
        drive_report(1'b0, 4'd3, 8'h01, 8'h00, 8'h00, 8'h00);
        drive_report(1'b0, 4'd3, 8'h02, 8'h00, 8'h00, 8'h00);
        drive_report(1'b0, 4'd3, 8'h04, 8'h00, 8'h00, 8'h00);
        drive_report(1'b0, 4'd3, 8'h00, 8'h00, 8'h00, 8'h00);
        drive_report(1'b0, 4'd4, 8'h00, 8'h00, 8'h00, 8'h01);
        drive_report(1'b0, 4'd5, 8'h00, 8'h00, 8'h00, 8'h02);
        drive_report(1'b0, 4'd6, 8'h00, 8'h00, 8'h00, 8'hFE);
        drive_report(1'b0, 4'd7, 8'h00, 8'h00, 8'h00, 8'h0F);
        drive_report(1'b0, 4'd4, 8'h00, 8'h00, 8'h00, 8'h83);
        drive_report(1'b0, 4'd3, 8'h00, 8'h80, 8'h7F, 8'h5A);
        drive_report(1'b0, 4'd3, 8'h00, 8'h7F, 8'h80, 8'h00);
        drive_report(1'b0, 4'd8, 8'hFF, 8'hFF, 8'h01, 8'hFF);
        drive_report(1'b0, 4'd8, 8'hFF, 8'h00, 8'h00, 8'hFF);
        drive_report(1'b0, 4'd3, 8'hFF, 8'h00, 8'h00, 8'h31);
        drive_report(1'b0, 4'd4, 8'hFF, 8'h00, 8'h00, 8'h00);
        drive_report(1'b0, 4'd4, 8'h03, 8'h01, 8'hFF, 8'hF1);
        drive_report(1'b0, 4'd3, 8'h00, 8'h00, 8'h00, 8'h00);

        while (good_count < GOOD_REPORTS) begin
            calm = (good_count >= CALM_FROM);
            random_report(counted);
            if (counted)
                good_count++;
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
